[design/distance_vector_route_table_unit_defines.svh]
// assertion macros shared by the route table modules
// no dependencies; taken in by `include where assertions are written
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DVRT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DVRT_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[design/dvrt_pkg.sv]
// types, codes and sizes of the distance-vector route table
// no dependencies; imported by dvrt_ctrl and the top level
package dvrt_pkg;

    // table size and derived widths
    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int WORD_W   = 64;
    localparam int NAME_W   = 4 * WORD_W;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int HOPS_W   = 32;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 3;
    localparam int CFG_IDX_W = 8;
    localparam int IN_DATA_W  = NAME_W + ADDR_W + PORT_W + HOPS_W;
    localparam int OUT_DATA_W = ADDR_W + PORT_W + HOPS_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_W0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_W1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_W2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_W3 = 8'd3;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_IMPROVED  = 3'd1,
        ST_KEPT      = 3'd2,
        ST_FULL      = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_DELETED   = 3'd6,
        ST_INVALID   = 3'd7
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ROUTE,
        S_APPLY,
        S_DONE
    } state_t;

    // one route memory word
    typedef struct packed {
        logic [HOPS_W-1:0] hops;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    // control of one memory port pair
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_ctl_t;

endpackage

[design/dvrt_ram.sv]
// generic simple dual-port synchronous memory with a registered read port
// depends on nothing
module dvrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/dvrt_ctrl.sv]
// sequencer of the route table: item capture, slot scan, read-modify-write
// and result register; uses dvrt_pkg and drives the name and route memories
`include "distance_vector_route_table_unit_defines.svh"

module dvrt_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [dvrt_pkg::NAME_W-1:0]     own_name,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dvrt_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [dvrt_pkg::OP_W-1:0]       s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dvrt_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [dvrt_pkg::STAT_W-1:0]     m_tuser,
    output logic                            m_tlast,
    output dvrt_pkg::ram_ctl_t              name_ctl,
    output logic [dvrt_pkg::NAME_W-1:0]     name_wdata,
    input  logic [dvrt_pkg::NAME_W-1:0]     name_rdata,
    output dvrt_pkg::ram_ctl_t              route_ctl,
    output dvrt_pkg::route_t                route_wdata,
    input  dvrt_pkg::route_t                route_rdata
);

    import dvrt_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [ENTRIES-1:0]  valid_bits_reg, valid_bits_next;
    logic                own_present_reg, own_present_next;

    // captured item
    logic [OP_W-1:0]     op_reg;
    logic [NAME_W-1:0]   key_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [HOPS_W-1:0]   recv_reg;
    logic                eom_reg;

    // pending result
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [PORT_W-1:0]   res_port_reg, res_port_next;
    logic [HOPS_W-1:0]   res_hops_reg, res_hops_next;

    // output register
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [STAT_W-1:0]       m_tuser_reg;
    logic                    m_tlast_reg;

    logic                in_take;
    logic                out_load;
    logic                in_bad;
    logic                own_hit;
    logic [HOPS_W-1:0]   new_hops;
    logic                slot_match;

    // decode of the incoming item
    assign in_bad = (s_tuser != OP_UPDATE && s_tuser != OP_LOOKUP && s_tuser != OP_DELETE)
                    || (s_tdata[NAME_W-1:0] == '0);

    // own entry and saturating hop count
    assign own_hit  = own_present_reg && (own_name != '0) && (own_name == key_reg);
    assign new_hops = (recv_reg == '1) ? recv_reg : recv_reg + HOPS_W'(1);

    // name match of the slot whose row has just come out of memory
    assign slot_match = (name_rdata == key_reg);

    // next state and memory control
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        valid_bits_next  = valid_bits_reg;
        own_present_next = own_present_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        res_port_next    = res_port_reg;
        res_hops_next    = res_hops_reg;
        name_ctl         = '0;
        name_wdata       = key_reg;
        route_ctl        = '0;
        route_wdata      = '{hops: new_hops, port: port_reg, addr: addr_reg};
        s_tready         = 1'b0;
        in_take          = 1'b0;
        out_load         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    in_take = 1'b1;
                    if (in_bad)
                    begin
                        res_status_next = ST_INVALID;
                        res_addr_next   = '0;
                        res_port_next   = '0;
                        res_hops_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cnt_next        = '0;
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one row read a cycle
                if (cnt_reg != CNT_W'(ENTRIES))
                begin
                    name_ctl.re    = 1'b1;
                    name_ctl.raddr = cnt_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = cnt_reg[IDX_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                // check the row read in the previous cycle
                if (chk_valid_reg)
                begin
                    if (valid_bits_reg[chk_idx_reg])
                    begin
                        if (!hit_found_reg && slot_match)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (chk_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_next = S_ROUTE;
                    end
                end
            end

            S_ROUTE:
            begin
                route_ctl.re    = 1'b1;
                route_ctl.raddr = hit_idx_reg;
                state_next      = S_APPLY;
            end

            S_APPLY:
            begin
                res_status_next = ST_INVALID;
                res_addr_next   = '0;
                res_port_next   = '0;
                res_hops_next   = '0;
                case (op_reg)
                    OP_UPDATE:
                    begin
                        if (own_hit)
                        begin
                            res_status_next = ST_KEPT;
                        end
                        else if (hit_found_reg)
                        begin
                            if (new_hops < route_rdata.hops)
                            begin
                                route_ctl.we    = 1'b1;
                                route_ctl.waddr = hit_idx_reg;
                                res_status_next = ST_IMPROVED;
                                res_hops_next   = new_hops;
                            end
                            else
                            begin
                                res_status_next = ST_KEPT;
                                res_hops_next   = route_rdata.hops;
                            end
                        end
                        else if (free_found_reg)
                        begin
                            name_ctl.we     = 1'b1;
                            name_ctl.waddr  = free_idx_reg;
                            route_ctl.we    = 1'b1;
                            route_ctl.waddr = free_idx_reg;
                            valid_bits_next[free_idx_reg] = 1'b1;
                            res_status_next = ST_INSERTED;
                            res_hops_next   = new_hops;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (own_hit)
                        begin
                            res_status_next = ST_FOUND;
                        end
                        else if (hit_found_reg)
                        begin
                            res_status_next = ST_FOUND;
                            res_addr_next   = route_rdata.addr;
                            res_port_next   = route_rdata.port;
                            res_hops_next   = route_rdata.hops;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (own_hit)
                        begin
                            own_present_next = 1'b0;
                            res_status_next  = ST_DELETED;
                        end
                        else if (hit_found_reg)
                        begin
                            valid_bits_next[hit_idx_reg] = 1'b0;
                            res_status_next = ST_DELETED;
                            res_hops_next   = route_rdata.hops;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_INVALID;
                    end
                endcase
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hand over once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            chk_valid_reg   <= 1'b0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            valid_bits_reg  <= '0;
            own_present_reg <= 1'b1;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            chk_valid_reg   <= chk_valid_next;
            hit_found_reg   <= hit_found_next;
            free_found_reg  <= free_found_next;
            valid_bits_reg  <= valid_bits_next;
            own_present_reg <= own_present_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_port_reg   <= res_port_next;
        res_hops_reg   <= res_hops_next;
        if (in_take)
        begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata[NAME_W-1:0];
            addr_reg <= s_tdata[NAME_W +: ADDR_W];
            port_reg <= s_tdata[NAME_W + ADDR_W +: PORT_W];
            recv_reg <= s_tdata[NAME_W + ADDR_W + PORT_W +: HOPS_W];
            eom_reg  <= s_tlast;
        end
        if (out_load)
        begin
            m_tdata_reg <= {res_hops_reg, res_port_reg, res_addr_reg};
            m_tuser_reg <= res_status_reg;
            m_tlast_reg <= eom_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    `DVRT_ASSERT_NXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `DVRT_ASSERT_IMP(a_insert_free, clk, rst_n, name_ctl.we, !valid_bits_reg[name_ctl.waddr], "insert into occupied slot")
    `DVRT_ASSERT_IMP(a_hit_valid, clk, rst_n, state_reg == S_ROUTE && hit_found_reg, valid_bits_reg[hit_idx_reg], "hit on empty slot")
    `DVRT_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load, !m_tvalid_reg || m_tready, "pending result overwritten")

endmodule

[design/distance_vector_route_table_unit.sv]
// Distance-vector route table: every item is an update, lookup or delete keyed by a 32-byte
// name and yields one result item. A valid item is accepted, then scanned through the name
// memory one row a cycle over all 128 slots, which finds both the lowest matching slot and
// the lowest free slot; then the route memory is read, the change is applied and the output
// register is loaded. An item with operation 3 or an all-zero name skips the scan. The next
// item is accepted while a result still waits in the output register. Configuration writes
// are always ready.
// top level: own name registers, sequencer and the name and route memories; uses dvrt_pkg,
// dvrt_ctrl and dvrt_ram
module distance_vector_route_table_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dvrt_pkg::WORD_W-1:0]      cfg_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_w0, key_w1, key_w2, key_w3, hop_address, hop_port, hops_received
    input  logic [dvrt_pkg::IN_DATA_W-1:0]   s_tdata,
    // operation
    input  logic [dvrt_pkg::OP_W-1:0]        s_tuser,
    // end_of_message
    input  logic                             s_tlast,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // route_address, route_port, route_hops
    output logic [dvrt_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status
    output logic [dvrt_pkg::STAT_W-1:0]      m_tuser,
    // message_done
    output logic                             m_tlast
);

    import dvrt_pkg::*;

    logic [WORD_W-1:0] own_w0_reg;
    logic [WORD_W-1:0] own_w1_reg;
    logic [WORD_W-1:0] own_w2_reg;
    logic [WORD_W-1:0] own_w3_reg;

    ram_ctl_t          name_ctl;
    logic [NAME_W-1:0] name_wdata;
    logic [NAME_W-1:0] name_rdata;
    ram_ctl_t          route_ctl;
    route_t            route_wdata;
    route_t            route_rdata;

    assign cfg_ready = 1'b1;

    // own name registers, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_w0_reg <= '0;
            own_w1_reg <= '0;
            own_w2_reg <= '0;
            own_w3_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_W0: own_w0_reg <= cfg_data;
                CFG_OWN_W1: own_w1_reg <= cfg_data;
                CFG_OWN_W2: own_w2_reg <= cfg_data;
                CFG_OWN_W3: own_w3_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer
    dvrt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .own_name    ({own_w3_reg, own_w2_reg, own_w1_reg, own_w0_reg}),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .name_ctl    (name_ctl),
        .name_wdata  (name_wdata),
        .name_rdata  (name_rdata),
        .route_ctl   (route_ctl),
        .route_wdata (route_wdata),
        .route_rdata (route_rdata)
    );

    // name memory, one four-word name per row
    dvrt_ram #(
        .WIDTH (NAME_W),
        .DEPTH (ENTRIES)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_ctl.we),
        .waddr (name_ctl.waddr),
        .wdata (name_wdata),
        .re    (name_ctl.re),
        .raddr (name_ctl.raddr),
        .rdata (name_rdata)
    );

    // route memory: next hop address, port and hop count
    dvrt_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (ENTRIES)
    ) u_route_ram (
        .clk   (clk),
        .we    (route_ctl.we),
        .waddr (route_ctl.waddr),
        .wdata (route_wdata),
        .re    (route_ctl.re),
        .raddr (route_ctl.raddr),
        .rdata (route_rdata)
    );

endmodule
